>>> sv/isc_pkg.sv
`default_nettype none

package isc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RATIO_BITS_DEF  = 8;

    localparam int VAL_W      = 16;
    localparam int COOL_W     = 10;
    localparam int SCORE_W    = 7;
    localparam int IDX_W      = 8;
    localparam int CFG_DATA_W = 16;

    localparam int ONE_G_MG = 1000;
    localparam int DEV_MAX  = 65535;

    localparam logic [VAL_W-1:0]   THRESHOLD_RESET  = 16'd5000;
    localparam logic [VAL_W-1:0]   FULL_SCALE_RESET = 16'd24000;
    localparam logic [COOL_W-1:0]  COOLDOWN_RESET   = 10'd100;
    localparam logic [SCORE_W-1:0] SCORE_TOP        = 7'd99;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_HIT_THRESHOLD = 2'd0;
    localparam reg_index_t REG_FULL_SCALE    = 2'd1;
    localparam reg_index_t REG_COOLDOWN      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT,
        ST_DEV,
        ST_DIV_GO,
        ST_DIV,
        ST_EMIT
    } phase_t;

    localparam int STEP_COUNT = 98;

    localparam logic [IDX_W-1:0] SCORE_STEP [STEP_COUNT] = '{
          1,   1,   2,   3,   4,   5,   6,   8,   9,  10,
         12,  13,  15,  16,  18,  19,  21,  23,  25,  27,
         28,  30,  32,  34,  36,  38,  41,  43,  45,  47,
         49,  51,  54,  56,  58,  61,  63,  66,  68,  71,
         73,  76,  78,  81,  83,  86,  89,  92,  94,  97,
        100, 103, 105, 108, 111, 114, 117, 120, 123, 126,
        129, 132, 135, 138, 141, 144, 147, 150, 153, 157,
        160, 163, 166, 169, 173, 176, 179, 183, 186, 189,
        193, 196, 200, 203, 206, 210, 213, 217, 220, 224,
        227, 231, 235, 238, 242, 245, 249, 253
    };

    typedef logic [SCORE_W-1:0] score_rom_t [2**IDX_W];

    // Each score is the number of curve steps already reached at that index.
    function automatic score_rom_t build_score_rom();
        score_rom_t         rom;
        logic [SCORE_W-1:0] s;
        for (int i = 0; i < 2**IDX_W; i++)
        begin
            s = '0;
            for (int k = 0; k < STEP_COUNT; k++)
            begin
                if (SCORE_STEP[k] <= IDX_W'(i))
                begin
                    s = s + 1'b1;
                end
            end
            rom[i] = s;
        end
        return rom;
    endfunction

    localparam score_rom_t SCORE_ROM = build_score_rom();

endpackage

`default_nettype wire

>>> sv/isc_if.sv
`default_nettype none

interface isc_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface isc_result_if;
    import isc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic [VAL_W-1:0]   deviation_mg;

    modport source (output valid, output score, output deviation_mg, input ready);
    modport sink (input valid, input score, input deviation_mg, output ready);
endinterface

`default_nettype wire

>>> sv/isc_isqrt.sv
`default_nettype none

module isc_isqrt #(
    parameter int RES_BITS = 17
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [2*RES_BITS-1:0] radicand,
    output logic                       done,
    output logic [RES_BITS-1:0]        root
);

    localparam int RAD_W = 2 * RES_BITS;
    localparam int REM_W = RES_BITS + 2;
    localparam int CNT_W = $clog2(RES_BITS + 1);

    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [RES_BITS-1:0] root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    trial;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(RES_BITS);
        end
        else if (cnt_reg != '0)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[RES_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[RES_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = (cnt_reg == CNT_W'(1));
    assign root = root_reg;

endmodule

`default_nettype wire

>>> sv/isc_divider.sv
`default_nettype none

module isc_divider #(
    parameter int Q_BITS = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [isc_pkg::VAL_W-1:0] dividend,
    input  wire logic [isc_pkg::VAL_W-1:0] divisor,
    output logic                         done,
    output logic [Q_BITS-1:0]            quotient
);

    import isc_pkg::*;

    localparam int CNT_W = $clog2(Q_BITS + 1);

    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [VAL_W-1:0]  div_reg, div_next;
    logic [Q_BITS-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VAL_W:0]    rem_shift;
    logic [VAL_W:0]    rem_diff;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, div_reg};
        rem_next  = rem_reg;
        div_next  = div_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next  = dividend;
            div_next  = divisor;
            quot_next = '0;
            cnt_next  = CNT_W'(Q_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (rem_shift >= {1'b0, div_reg})
            begin
                rem_next  = rem_diff[VAL_W-1:0];
                quot_next = {quot_reg[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[VAL_W-1:0];
                quot_next = {quot_reg[Q_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign done     = (cnt_reg == CNT_W'(1));
    assign quotient = quot_reg;

endmodule

`default_nettype wire

>>> sv/impact_strength_scorer.sv
// Impact strength scorer.
// The sample channel carries one three-axis accelerometer sample in signed
// milli-g per transaction. The result channel carries one transaction, a score
// of 0 to 99 and the deviation from one g, for each sample that is a hit; other
// samples produce nothing. The plain write port sets the hit threshold, the
// full-scale deviation and the cooldown length; the user must write it only
// while the block is idle, which the block itself does not enforce. One shared
// multiplier squares the three axes one after another, a bit-serial root unit
// follows, and a hit below full scale goes through a restoring divider before
// the score table. Only one sample is in flight at a time.
// The result sits in an output register, so the next sample is accepted while
// a result waits. If the receiver stalls, the following hit holds in its last
// step until the register is free, and sample ready stays low meanwhile.
// Reset restores the register defaults, clears the cooldown and drops any
// pending result.
`default_nettype none

module impact_strength_scorer #(
    parameter int SAMPLE_BITS = isc_pkg::SAMPLE_BITS_DEF,
    parameter int RATIO_BITS  = isc_pkg::RATIO_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    isc_sample_if.sink                          sample,
    isc_result_if.source                        result,
    input  wire logic                           cfg_we,
    input  wire isc_pkg::reg_index_t            cfg_index,
    input  wire logic [isc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import isc_pkg::*;

    localparam int SUM_W  = 2 * SAMPLE_BITS + 2;
    localparam int ROOT_W = SAMPLE_BITS + 1;
    localparam int CMP_W  = (ROOT_W > VAL_W + 1) ? ROOT_W : VAL_W + 1;
    localparam int SHR    = (RATIO_BITS >= IDX_W) ? RATIO_BITS - IDX_W : 0;
    localparam int SHL    = (RATIO_BITS >= IDX_W) ? 0 : IDX_W - RATIO_BITS;
    localparam int SCL_W  = RATIO_BITS + IDX_W;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             sq_idx_reg, sq_idx_next;
    logic [SAMPLE_BITS-1:0] mx_reg, my_reg, mz_reg;
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic [VAL_W-1:0]       dev_reg, dev_next;
    logic                   top_hit_reg, top_hit_next;
    logic [COOL_W-1:0]      cool_reg, cool_next;
    logic [VAL_W-1:0]       thr_reg, fs_reg;
    logic [COOL_W-1:0]      cds_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0]     out_score_reg, out_score_next;
    logic [VAL_W-1:0]       out_dev_reg, out_dev_next;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] sq_op;
    logic [2*SAMPLE_BITS-1:0] sq_prod;
    logic                   root_done;
    logic [ROOT_W-1:0]      root_val;
    logic [CMP_W-1:0]       root_wide;
    logic [CMP_W-1:0]       diff;
    logic [VAL_W-1:0]       dev_calc;
    logic [VAL_W-1:0]       fs_eff;
    logic                   div_done;
    logic [RATIO_BITS-1:0]  quot;
    logic [SCL_W-1:0]       quot_scaled;
    logic [IDX_W-1:0]       score_idx;

    function automatic logic [SAMPLE_BITS-1:0] magnitude(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        logic [SAMPLE_BITS-1:0] u;
        u = v;
        return v[SAMPLE_BITS-1] ? (~u + 1'b1) : u;
    endfunction

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (phase_reg == ST_IDLE);

    always_comb
    begin
        case (sq_idx_reg)
            2'd0:    sq_op = mx_reg;
            2'd1:    sq_op = my_reg;
            default: sq_op = mz_reg;
        endcase
    end

    assign sq_prod = sq_op * sq_op;

    isc_isqrt #(
        .RES_BITS (ROOT_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (phase_reg == ST_ROOT_GO),
        .radicand (acc_reg),
        .done     (root_done),
        .root     (root_val)
    );

    assign fs_eff = (fs_reg == '0) ? VAL_W'(1) : fs_reg;

    isc_divider #(
        .Q_BITS (RATIO_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (phase_reg == ST_DIV_GO),
        .dividend (dev_reg),
        .divisor  (fs_eff),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        root_wide = CMP_W'(root_val);
        if (root_wide >= CMP_W'(ONE_G_MG))
        begin
            diff = root_wide - CMP_W'(ONE_G_MG);
        end
        else
        begin
            diff = CMP_W'(ONE_G_MG) - root_wide;
        end
        dev_calc = (diff > CMP_W'(DEV_MAX)) ? VAL_W'(DEV_MAX) : diff[VAL_W-1:0];
    end

    assign quot_scaled = (SCL_W'(quot) << SHL) >> SHR;
    assign score_idx   = quot_scaled[IDX_W-1:0];

    always_comb
    begin
        phase_next     = phase_reg;
        sq_idx_next    = sq_idx_reg;
        acc_next       = acc_reg;
        dev_next       = dev_reg;
        top_hit_next   = top_hit_reg;
        cool_next      = cool_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_score_next = out_score_reg;
        out_dev_next   = out_dev_reg;
        case (phase_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    acc_next    = '0;
                    sq_idx_next = '0;
                    phase_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                acc_next    = acc_reg + SUM_W'(sq_prod);
                sq_idx_next = sq_idx_reg + 1'b1;
                if (sq_idx_reg == 2'd2)
                begin
                    phase_next = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO:
            begin
                phase_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    phase_next = ST_DEV;
                end
            end
            ST_DEV:
            begin
                dev_next = dev_calc;
                if (cool_reg != '0)
                begin
                    cool_next  = cool_reg - 1'b1;
                    phase_next = ST_IDLE;
                end
                else if (dev_calc <= thr_reg)
                begin
                    phase_next = ST_IDLE;
                end
                else
                begin
                    cool_next    = cds_reg;
                    top_hit_next = (dev_calc >= fs_eff);
                    phase_next   = (dev_calc >= fs_eff) ? ST_EMIT : ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                phase_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    phase_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_score_next = top_hit_reg ? SCORE_TOP : SCORE_ROM[score_idx];
                    out_dev_next   = dev_reg;
                    phase_next     = ST_IDLE;
                end
            end
            default:
            begin
                phase_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ST_IDLE;
            sq_idx_reg    <= '0;
            cool_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sq_idx_reg    <= sq_idx_next;
            cool_reg      <= cool_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        dev_reg       <= dev_next;
        top_hit_reg   <= top_hit_next;
        out_score_reg <= out_score_next;
        out_dev_reg   <= out_dev_next;
        if (accept)
        begin
            mx_reg <= magnitude(sample.accel_x);
            my_reg <= magnitude(sample.accel_y);
            mz_reg <= magnitude(sample.accel_z);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
            fs_reg  <= FULL_SCALE_RESET;
            cds_reg <= COOLDOWN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HIT_THRESHOLD: thr_reg <= cfg_data[VAL_W-1:0];
                REG_FULL_SCALE:    fs_reg  <= cfg_data[VAL_W-1:0];
                REG_COOLDOWN:      cds_reg <= cfg_data[COOL_W-1:0];
                default:           thr_reg <= thr_reg;
            endcase
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.score        = out_score_reg;
    assign result.deviation_mg = out_dev_reg;

endmodule

`default_nettype wire

>>> sv/isc_checker.sv
`default_nettype none

module isc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [isc_pkg::SCORE_W-1:0] out_score,
    input wire logic [isc_pkg::VAL_W-1:0]   out_dev
);

    import isc_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Every sample takes the block out of idle, so ready falls right after a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while busy");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_score <= SCORE_TOP)
        else $error("score above the top of the curve");

    // A hit needs a deviation strictly above a non-negative threshold.
    a_dev_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_dev != '0)
        else $error("hit reported with zero deviation");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered during reset");

endmodule

bind impact_strength_scorer isc_checker u_isc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_score (result.score),
    .out_dev   (result.deviation_mg)
);

`default_nettype wire
